// ===== hdl/stp2p_pkg.sv =====
// shared types, constants and the plane packing function for the tile converter
package stp2p_pkg;

	localparam int unsigned ByteW   = 8;
	localparam int unsigned WordW   = 32;
	localparam int unsigned PosW    = 5;
	localparam int unsigned RowIdxW = 4;
	localparam int unsigned NumRows = 16;
	localparam int unsigned UserW   = 1;

	// plane order register codes
	typedef enum logic {
		ORDER_CART = 1'b0,
		ORDER_CD   = 1'b1
	} plane_order_t;

	// one result as it sits in the output stage
	typedef struct packed {
		logic [WordW-1:0] packed_word;
		logic             last_of_run;
		logic             region_done;
	} out_item_t;

	// pixel x takes bit x of each plane: msb from p3 down to lsb from p0
	function automatic logic [WordW-1:0] pack_planes(
		input logic [ByteW-1:0] p3,
		input logic [ByteW-1:0] p2,
		input logic [ByteW-1:0] p1,
		input logic [ByteW-1:0] p0
	);
		logic [WordW-1:0] word;
		word = '0;
		for (int x = 0; x < ByteW; x++) begin
			word[4*x +: 4] = {p3[x], p2[x], p1[x], p0[x]};
		end
		return word;
	endfunction

endpackage

// ===== hdl/sprite_tile_planar_to_packed.sv =====
// planar to packed 4bpp converter for 16x16 sprite tiles
//
//  channel   | direction | tdata / data           | tlast / tuser
//  ----------+-----------+------------------------+---------------------------
//  s_axis    | in        | byte_0..byte_3 (32 b)  | tlast = final_word
//  m_axis    | out       | packed_word (32 b)     | tlast = last_of_run,
//            |           |                        | tuser = region_done
//  cfg       | in        | plane_order (1 b)      | -
//
//  first-half words (tile positions 0..15) give no result and never wait on the output side
//  second-half words give two results, which both leave through the output
//  side: the output stage holds one result plus one pending result
//  a request passes the input stage, then the output stage, before its first result
//  reset clears the tile position, the plane order and all valid flags;
//  the stored first-half rows keep whatever they held
//  a stall on m_axis backs up into s_axis only once a second-half word waits
module sprite_tile_planar_to_packed (
	input  logic                      clk,
	input  logic                      arst_n,
	// cfg write channel
	input  logic                      cfg_valid,
	output logic                      cfg_ready,
	input  logic                      cfg_data,       // plane_order
	// input stream
	input  logic                      s_axis_tvalid,
	output logic                      s_axis_tready,
	input  logic [stp2p_pkg::WordW-1:0] s_axis_tdata, // byte_0, byte_1, byte_2, byte_3
	input  logic                      s_axis_tlast,   // final_word
	// output stream
	output logic                      m_axis_tvalid,
	input  logic                      m_axis_tready,
	output logic [stp2p_pkg::WordW-1:0] m_axis_tdata, // packed_word
	output logic                      m_axis_tlast,   // last_of_run
	output logic [stp2p_pkg::UserW-1:0] m_axis_tuser  // region_done
);
	import stp2p_pkg::*;

	// configuration
	plane_order_t plane_order_q;

	// tile position of the next incoming word
	logic [PosW-1:0] tile_pos_q;

	// input stage
	logic             v_s1;
	logic [WordW-1:0] data_s1;
	logic             final_s1;
	logic [PosW-1:0]  pos_s1;

	// first-half rows, written by words 0..15 of a tile
	logic [WordW-1:0] rows_q [NumRows];

	// output stage and pending second result
	logic      out_v_q;
	out_item_t out_q;
	logic      pend_v_q;
	out_item_t pend_q;

	logic [ByteW-1:0] b0, b1, b2, b3;
	logic [WordW-1:0] conv_word;
	logic [WordW-1:0] stored_word;
	logic             second_half;
	logic             out_free;
	logic             adv;
	logic             s_acc;

	assign cfg_ready = 1'b1;

	assign b0 = data_s1[0*ByteW +: ByteW];
	assign b1 = data_s1[1*ByteW +: ByteW];
	assign b2 = data_s1[2*ByteW +: ByteW];
	assign b3 = data_s1[3*ByteW +: ByteW];

	// nibble bit order depends on the plane layout of the source
	always_comb begin
		unique case (plane_order_q)
			ORDER_CD:   conv_word = pack_planes(b3, b2, b1, b0);
			ORDER_CART: conv_word = pack_planes(b3, b1, b2, b0);
			default:    conv_word = pack_planes(b3, b1, b2, b0);
		endcase
	end

	assign second_half = pos_s1[PosW-1];
	assign stored_word = rows_q[pos_s1[RowIdxW-1:0]];

	// first-half words always leave; second-half words need both output slots
	assign out_free = !out_v_q || m_axis_tready;
	assign adv      = v_s1 && (!second_half || (out_free && !pend_v_q));

	assign s_axis_tready = !v_s1 || adv;
	assign s_acc         = s_axis_tvalid && s_axis_tready;

	// control state
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			plane_order_q <= ORDER_CART;
			tile_pos_q    <= '0;
			v_s1          <= 1'b0;
			out_v_q       <= 1'b0;
			pend_v_q      <= 1'b0;
		end else begin
			if (cfg_valid && cfg_ready) begin
				plane_order_q <= plane_order_t'(cfg_data);
			end
			// final word ends the region, else wrap through the 32-word tile
			if (s_acc) begin
				tile_pos_q <= s_axis_tlast ? '0 : tile_pos_q + 1'b1;
			end
			if (s_acc) begin
				v_s1 <= 1'b1;
			end else if (adv) begin
				v_s1 <= 1'b0;
			end
			if (out_free) begin
				if (pend_v_q) begin
					out_v_q  <= 1'b1;
					pend_v_q <= 1'b0;
				end else if (adv && second_half) begin
					out_v_q  <= 1'b1;
					pend_v_q <= 1'b1;
				end else begin
					out_v_q  <= 1'b0;
				end
			end
		end
	end

	// payload of the input stage
	always_ff @(posedge clk) begin
		if (s_acc) begin
			data_s1  <= s_axis_tdata;
			final_s1 <= s_axis_tlast;
			pos_s1   <= tile_pos_q;
		end
	end

	// row store
	always_ff @(posedge clk) begin
		if (adv && !second_half) begin
			rows_q[pos_s1[RowIdxW-1:0]] <= conv_word;
		end
	end

	// output payload: own word first, then the stored row
	always_ff @(posedge clk) begin
		if (out_free) begin
			if (pend_v_q) begin
				out_q <= pend_q;
			end else if (adv && second_half) begin
				out_q.packed_word  <= conv_word;
				out_q.last_of_run  <= 1'b0;
				out_q.region_done  <= 1'b0;
				pend_q.packed_word <= stored_word;
				pend_q.last_of_run <= 1'b1;
				pend_q.region_done <= final_s1;
			end
		end
	end

	assign m_axis_tvalid = out_v_q;
	assign m_axis_tdata  = out_q.packed_word;
	assign m_axis_tlast  = out_q.last_of_run;
	assign m_axis_tuser  = UserW'(out_q.region_done);

endmodule

// ===== hdl/stp2p_chk.sv =====
// port-level checker for the tile converter and its bind
module stp2p_chk (
	input logic                        clk,
	input logic                        arst_n,
	input logic                        cfg_valid,
	input logic                        cfg_ready,
	input logic                        cfg_data,
	input logic                        s_axis_tvalid,
	input logic                        s_axis_tready,
	input logic [stp2p_pkg::WordW-1:0] s_axis_tdata,
	input logic                        s_axis_tlast,
	input logic                        m_axis_tvalid,
	input logic                        m_axis_tready,
	input logic [stp2p_pkg::WordW-1:0] m_axis_tdata,
	input logic                        m_axis_tlast,
	input logic [stp2p_pkg::UserW-1:0] m_axis_tuser
);
	import stp2p_pkg::*;

	logic unused_in;
	assign unused_in = cfg_valid ^ cfg_data ^ s_axis_tvalid ^ s_axis_tready ^
		(^s_axis_tdata) ^ s_axis_tlast;

	// stalled result holds
	a_out_hold: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && !m_axis_tready |=>
			m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast) &&
			$stable(m_axis_tuser))
		else $error("result changed while stalled");

	// region end only on the second result of a word
	a_done_last: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && (m_axis_tuser != '0) |-> m_axis_tlast)
		else $error("region_done without last_of_run");

	// the stored row follows its own word right away
	a_pair: assert property (@(posedge clk) disable iff (!arst_n)
		m_axis_tvalid && m_axis_tready && !m_axis_tlast |=>
			m_axis_tvalid && m_axis_tlast)
		else $error("second result missing after first");

	// config port never stalls
	a_cfg_rdy: assert property (@(posedge clk) disable iff (!arst_n)
		cfg_ready)
		else $error("cfg_ready low");

endmodule

bind sprite_tile_planar_to_packed stp2p_chk u_stp2p_chk (.*);

// ===== tb/sv/sprite_tile_planar_to_packed_tb.sv =====
`timescale 1ns / 100ps
// self-checking testbench for the planar to packed sprite tile converter
module sprite_tile_planar_to_packed_tb;
	import stp2p_pkg::*;

	localparam int TileWords    = 2 * NumRows;
	localparam int SettleCycles = 8;
	localparam int HoldCycles   = 250;
	localparam int MaxShown     = 10;
	localparam int PhaseWords   = 300;

	// one expected output beat
	typedef struct packed {
		logic [WordW-1:0] pixels;
		logic             run_end;
		logic             region_end;
	} tile_result_t;

	logic                clk;
	logic                arst_n;
	logic                cfg_valid;
	logic                cfg_ready;
	logic                cfg_data;
	logic                s_axis_tvalid;
	logic                s_axis_tready;
	logic [WordW-1:0]    s_axis_tdata;
	logic                s_axis_tlast;
	logic                m_axis_tvalid;
	logic                m_axis_tready;
	logic [WordW-1:0]    m_axis_tdata;
	logic                m_axis_tlast;
	logic [UserW-1:0]    m_axis_tuser;

	// predictor state
	tile_result_t        expected_results[$];
	plane_order_t        cur_order;
	logic [PosW-1:0]     tile_pos;
	logic [WordW-1:0]    first_half_store [NumRows];

	int                  mismatch_count;
	int                  tx_idle_pct;
	int                  rx_stall_pct;
	int                  words_sent;
	bit                  rx_hold;
	event                hold_go;

	sprite_tile_planar_to_packed dut (
		.clk           (clk),
		.arst_n        (arst_n),
		.cfg_valid     (cfg_valid),
		.cfg_ready     (cfg_ready),
		.cfg_data      (cfg_data),
		.s_axis_tvalid (s_axis_tvalid),
		.s_axis_tready (s_axis_tready),
		.s_axis_tdata  (s_axis_tdata),
		.s_axis_tlast  (s_axis_tlast),
		.m_axis_tvalid (m_axis_tvalid),
		.m_axis_tready (m_axis_tready),
		.m_axis_tdata  (m_axis_tdata),
		.m_axis_tlast  (m_axis_tlast),
		.m_axis_tuser  (m_axis_tuser)
	);

	initial begin
		clk = 1'b0;
		forever #10 clk = ~clk;
	end

	// pixel x gets bit x of each plane, msb plane first
	function automatic logic [WordW-1:0] interleave_planes(
		input logic [ByteW-1:0] n3,
		input logic [ByteW-1:0] n2,
		input logic [ByteW-1:0] n1,
		input logic [ByteW-1:0] n0
	);
		logic [WordW-1:0] w;
		w = '0;
		for (int x = 0; x < ByteW; x++) begin
			w[4*x + 3] = n3[x];
			w[4*x + 2] = n2[x];
			w[4*x + 1] = n1[x];
			w[4*x]     = n0[x];
		end
		return w;
	endfunction

	// plane byte with extra weight on all-zero and all-one
	function automatic logic [ByteW-1:0] rand_plane();
		int pick;
		pick = $urandom_range(0, 9);
		if (pick == 0) return '0;
		if (pick == 1) return '1;
		return ByteW'($urandom);
	endfunction

	// updates tile state for one accepted request and queues its results
	task automatic predict_tile_word(
		input logic [ByteW-1:0] b0,
		input logic [ByteW-1:0] b1,
		input logic [ByteW-1:0] b2,
		input logic [ByteW-1:0] b3,
		input logic             fin
	);
		logic [WordW-1:0] word;
		if (cur_order == ORDER_CD)
			word = interleave_planes(b3, b2, b1, b0);
		else
			word = interleave_planes(b3, b1, b2, b0);
		if (tile_pos < NumRows) begin
			first_half_store[tile_pos[RowIdxW-1:0]] = word;
		end else begin
			expected_results.push_back('{pixels: word, run_end: 1'b0, region_end: 1'b0});
			expected_results.push_back('{pixels: first_half_store[tile_pos[RowIdxW-1:0]],
				run_end: 1'b1, region_end: fin});
		end
		tile_pos = fin ? '0 : tile_pos + 1'b1;
	endtask

	// offers one request, with random gaps before it
	task automatic send_word(
		input logic [ByteW-1:0] b0,
		input logic [ByteW-1:0] b1,
		input logic [ByteW-1:0] b2,
		input logic [ByteW-1:0] b3,
		input logic             fin
	);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata  <= {b3, b2, b1, b0};
		s_axis_tlast  <= fin;
		@(posedge clk);
		while (!s_axis_tready) @(posedge clk);
		predict_tile_word(b0, b1, b2, b3, fin);
		words_sent++;
	endtask

	// stop offering and let everything in flight come out
	task automatic drain_block();
		s_axis_tvalid <= 1'b0;
		while (expected_results.size() != 0) @(posedge clk);
		repeat (SettleCycles) @(posedge clk);
	endtask

	task automatic write_order(input plane_order_t order);
		cfg_valid <= 1'b1;
		cfg_data  <= order;
		@(posedge clk);
		while (!cfg_ready) @(posedge clk);
		cfg_valid <= 1'b0;
		cur_order = order;
	endtask

	// one region: mostly whole tiles, some ending mid second half,
	// some wrapping with no final word, a few partial tiles as noise
	task automatic send_region();
		int   kind;
		int   tiles;
		int   n;
		logic fin_at_end;
		kind  = $urandom_range(0, 99);
		tiles = $urandom_range(1, 2);
		if (kind < 55) begin
			n = TileWords * tiles;
			fin_at_end = 1'b1;
		end else if (kind < 75) begin
			n = TileWords * (tiles - 1) + NumRows + $urandom_range(1, NumRows);
			fin_at_end = 1'b1;
		end else if (kind < 85) begin
			n = TileWords * tiles;
			fin_at_end = 1'b0;
		end else begin
			n = $urandom_range(1, NumRows);
			fin_at_end = 1'b1;
		end
		for (int i = 0; i < n; i++)
			send_word(rand_plane(), rand_plane(), rand_plane(), rand_plane(),
				fin_at_end && (i == n - 1));
	endtask

	task automatic run_random_stream(
		input plane_order_t order,
		input int           tx_pct,
		input int           rx_pct,
		input bit           with_hold
	);
		drain_block();
		write_order(order);
		tx_idle_pct  = tx_pct;
		rx_stall_pct = rx_pct;
		words_sent   = 0;
		if (with_hold) -> hold_go;
		while (words_sent < PhaseWords) send_region();
	endtask

	// final word among the first half: region closes with no output
	task automatic test_partial_tile_dropped();
		send_word(8'h00, 8'h00, 8'h00, 8'h00, 1'b0);
		send_word(8'hFF, 8'hFF, 8'hFF, 8'hFF, 1'b0);
		send_word(8'h01, 8'h02, 8'h04, 8'h08, 1'b0);
		send_word(8'h80, 8'h40, 8'h20, 8'h10, 1'b1);
	endtask

	// full first half, then a final word on row 0 of the second half
	task automatic test_final_in_second_half();
		logic [ByteW-1:0] lo;
		logic [ByteW-1:0] hi;
		for (int r = 0; r < NumRows; r++) begin
			lo = 8'h01 << (r % ByteW);
			hi = 8'h80 >> (r % ByteW);
			send_word(lo, hi, r[0] ? 8'hAA : 8'h55, (r < ByteW) ? 8'h00 : 8'hFF, 1'b0);
		end
		send_word(8'h0F, 8'hF0, 8'h33, 8'hCC, 1'b1);
	endtask

	task automatic test_no_idling();
		run_random_stream(ORDER_CD, 0, 0, 1'b0);
	endtask

	task automatic test_sender_gaps();
		run_random_stream(ORDER_CART, 78, 0, 1'b0);
	endtask

	// long receiver hold while requests keep coming, backs up into the input
	task automatic test_receiver_stalls();
		run_random_stream(ORDER_CD, 0, 78, 1'b1);
	endtask

	task automatic test_both_idle();
		run_random_stream(ORDER_CART, 32, 32, 1'b0);
	endtask

	// long receiver hold-off, counted here
	initial begin
		rx_hold = 1'b0;
		forever begin
			@(hold_go);
			rx_hold <= 1'b1;
			repeat (HoldCycles) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	always @(posedge clk) begin
		m_axis_tready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
	end

	// compare every accepted result with the oldest prediction
	always @(posedge clk) begin : check_results
		tile_result_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_results.size() == 0) begin
				mismatch_count++;
				if (mismatch_count <= MaxShown)
					$display("unexpected result: word %h last %b done %b",
						m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
			end else begin
				want = expected_results.pop_front();
				if (m_axis_tdata !== want.pixels || m_axis_tlast !== want.run_end ||
						m_axis_tuser[0] !== want.region_end) begin
					mismatch_count++;
					if (mismatch_count <= MaxShown)
						$display("mismatch: expected word %h last %b done %b, got %h %b %b",
							want.pixels, want.run_end, want.region_end,
							m_axis_tdata, m_axis_tlast, m_axis_tuser[0]);
				end
			end
		end
	end

	initial begin
		#8_000_000;
		$display("== FAIL ==");
		$finish;
	end

	initial begin
		arst_n        <= 1'b0;
		cfg_valid     <= 1'b0;
		cfg_data      <= 1'b0;
		s_axis_tvalid <= 1'b0;
		s_axis_tdata  <= '0;
		s_axis_tlast  <= 1'b0;
		m_axis_tready <= 1'b0;
		tx_idle_pct    = 0;
		rx_stall_pct   = 0;
		mismatch_count = 0;
		words_sent     = 0;
		cur_order      = ORDER_CART;
		tile_pos       = '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_partial_tile_dropped();
		test_final_in_second_half();
		test_no_idling();
		test_sender_gaps();
		test_receiver_stalls();
		test_both_idle();
		drain_block();

		if (mismatch_count == 0 && expected_results.size() == 0)
			$display("== PASS ==");
		else
			$display("== FAIL ==");
		$finish;
	end

endmodule
